// ===== rtl/nrrq_pkg.sv =====
// Package: shared types, codes and defaults for the notify/request rendezvous queue.
package nrrq_pkg;

  localparam int NOTE_DEPTH_DEF = 64;
  localparam int WAIT_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF = 64;

  localparam int REQ_W    = 2;
  localparam int TAG_W    = 16;
  localparam int DATA_P_W = 64;
  localparam int STATUS_W = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_SEND   = 2'd0,
    REQ_RECV   = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_RSVD   = 2'd3
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DELIVERED = 3'd0,
    ST_PENDING   = 3'd1,
    ST_TOO_SMALL = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_QUEUED    = 3'd5,
    ST_DROPPED   = 3'd6,
    ST_PEND_FULL = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEND_DELIVER,
    OP_SEND_QUEUE,
    OP_SEND_DROP,
    OP_RECV_SMALL,
    OP_RECV_DELIVER,
    OP_RECV_PEND,
    OP_RECV_FULL,
    OP_CANCEL_HIT,
    OP_CANCEL_MISS
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      fits;
    logic      wait_any;
    logic      wait_full;
    logic      note_any;
    logic      note_full;
    logic      match_any;
  } sts_t;

endpackage

// ===== rtl/nrrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module nrrq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nrrq_dp.sv =====
// Datapath: request capture, notification FIFO, waiting-tag queue and result registers.
module nrrq_dp #(
  parameter int NOTE_DEPTH = nrrq_pkg::NOTE_DEPTH_DEF,
  parameter int WAIT_DEPTH = nrrq_pkg::WAIT_DEPTH_DEF,
  parameter int DATA_WIDTH = nrrq_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nrrq_pkg::cmd_t                  cmd,
  output nrrq_pkg::sts_t                  sts,
  input  logic [nrrq_pkg::REQ_W-1:0]      in_req_type,
  input  logic [nrrq_pkg::DATA_P_W-1:0]   in_notify_data,
  input  logic [nrrq_pkg::TAG_W-1:0]      in_request_tag,
  input  logic                            in_buffer_fits,
  output logic                            out_valid,
  output logic [nrrq_pkg::STATUS_W-1:0]   out_status_code,
  output logic [nrrq_pkg::TAG_W-1:0]      out_completed_tag,
  output logic [nrrq_pkg::DATA_P_W-1:0]   out_delivered_data
);
  import nrrq_pkg::*;

  localparam int NAW = $clog2(NOTE_DEPTH);
  localparam int NCW = $clog2(NOTE_DEPTH + 1);
  localparam int WCW = $clog2(WAIT_DEPTH + 1);

  // captured request
  req_type_t             type_r;
  logic [DATA_WIDTH-1:0] data_r;
  logic [TAG_W-1:0]      tag_r;
  logic                  fits_r;
  logic [WAIT_DEPTH-1:0] match_r, match_nxt;

  // notification FIFO pointers
  logic [NAW-1:0] note_head_r, note_head_nxt;
  logic [NCW-1:0] note_count_r, note_count_nxt;
  logic [NAW:0]   note_sum;
  logic [NAW-1:0] note_waddr;
  logic           note_we;
  logic [DATA_WIDTH-1:0] note_rdata;

  // waiting tags, oldest at entry 0
  logic [TAG_W-1:0] wait_q_r   [WAIT_DEPTH];
  logic [TAG_W-1:0] wait_q_nxt [WAIT_DEPTH];
  logic [WCW-1:0]   wait_count_r, wait_count_nxt;
  logic [WAIT_DEPTH-1:0] shift_mask;

  logic                out_valid_r;
  status_t             out_status_r, out_status_nxt;
  logic [TAG_W-1:0]    out_tag_r, out_tag_nxt;
  logic [DATA_P_W-1:0] out_data_r, out_data_nxt;

  nrrq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NOTE_DEPTH)) u_note_ram (
    .clk   (clk),
    .we    (note_we),
    .waddr (note_waddr),
    .wdata (data_r),
    .raddr (note_head_r),
    .rdata (note_rdata)
  );

  // tag compare against live entries, taken at capture
  always_comb begin
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      match_nxt[i] = (wait_q_r[i] == in_request_tag) && (WCW'(i) < wait_count_r);
    end
  end

  always_comb begin
    note_sum   = {1'b0, note_head_r} + (NAW+1)'(note_count_r);
    note_waddr = (note_sum >= (NAW+1)'(NOTE_DEPTH)) ?
                 NAW'(note_sum - (NAW+1)'(NOTE_DEPTH)) : NAW'(note_sum);
    note_we    = cmd.exec && (cmd.op == OP_SEND_QUEUE);
  end

  always_comb begin
    note_head_nxt  = note_head_r;
    note_count_nxt = note_count_r;
    wait_count_nxt = wait_count_r;
    shift_mask     = '0;
    out_status_nxt = ST_NOT_FOUND;
    out_tag_nxt    = tag_r;
    out_data_nxt   = '0;
    case (cmd.op)
      OP_SEND_DELIVER: begin
        shift_mask     = '1;
        wait_count_nxt = wait_count_r - 1'b1;
        out_status_nxt = ST_DELIVERED;
        out_tag_nxt    = wait_q_r[0];
        out_data_nxt   = DATA_P_W'(data_r);
      end
      OP_SEND_QUEUE: begin
        note_count_nxt = note_count_r + 1'b1;
        out_status_nxt = ST_QUEUED;
        out_tag_nxt    = '0;
      end
      OP_SEND_DROP: begin
        out_status_nxt = ST_DROPPED;
        out_tag_nxt    = '0;
      end
      OP_RECV_SMALL: out_status_nxt = ST_TOO_SMALL;
      OP_RECV_DELIVER: begin
        note_head_nxt  = (note_head_r == NAW'(NOTE_DEPTH - 1)) ? '0 : note_head_r + 1'b1;
        note_count_nxt = note_count_r - 1'b1;
        out_status_nxt = ST_DELIVERED;
        out_data_nxt   = DATA_P_W'(note_rdata);
      end
      OP_RECV_PEND: begin
        wait_count_nxt = wait_count_r + 1'b1;
        out_status_nxt = ST_PENDING;
      end
      OP_RECV_FULL: out_status_nxt = ST_PEND_FULL;
      OP_CANCEL_HIT: begin
        // everything at or above the oldest match moves down one
        shift_mask     = match_r | (~match_r + 1'b1);
        wait_count_nxt = wait_count_r - 1'b1;
        out_status_nxt = ST_CANCELLED;
      end
      OP_CANCEL_MISS: out_status_nxt = ST_NOT_FOUND;
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      wait_q_nxt[i] = wait_q_r[i];
      if (cmd.op == OP_RECV_PEND && wait_count_r == WCW'(i)) begin
        wait_q_nxt[i] = tag_r;
      end
    end
    for (int i = 0; i < WAIT_DEPTH - 1; i++) begin
      if (shift_mask[i]) begin
        wait_q_nxt[i] = wait_q_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r  <= req_type_t'(in_req_type);
      data_r  <= in_notify_data[DATA_WIDTH-1:0];
      tag_r   <= in_request_tag;
      fits_r  <= in_buffer_fits;
      match_r <= match_nxt;
    end
    if (cmd.exec) begin
      wait_q_r     <= wait_q_nxt;
      out_status_r <= out_status_nxt;
      out_tag_r    <= out_tag_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      note_head_r  <= '0;
      note_count_r <= '0;
      wait_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec && (cmd.op != OP_NONE);
      if (cmd.exec) begin
        note_head_r  <= note_head_nxt;
        note_count_r <= note_count_nxt;
        wait_count_r <= wait_count_nxt;
      end
    end
  end

  always_comb begin
    sts.req_type  = type_r;
    sts.fits      = fits_r;
    sts.wait_any  = (wait_count_r != '0);
    sts.wait_full = (wait_count_r == WCW'(WAIT_DEPTH));
    sts.note_any  = (note_count_r != '0);
    sts.note_full = (note_count_r == NCW'(NOTE_DEPTH));
    sts.match_any = |match_r;
  end

  assign out_valid          = out_valid_r;
  assign out_status_code    = out_status_r;
  assign out_completed_tag  = out_tag_r;
  assign out_delivered_data = out_data_r;

endmodule

// ===== rtl/nrrq_ctrl.sv =====
// Controller: two-state sequencer that picks the operation for each request.
module nrrq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  nrrq_pkg::sts_t sts,
  output nrrq_pkg::cmd_t cmd
);
  import nrrq_pkg::*;

  state_t state_r, state_nxt;
  op_t    op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // operation decode from captured request and queue status
  always_comb begin
    op = OP_NONE;
    case (sts.req_type)
      REQ_SEND: begin
        if (sts.wait_any)        op = OP_SEND_DELIVER;
        else if (!sts.note_full) op = OP_SEND_QUEUE;
        else                     op = OP_SEND_DROP;
      end
      REQ_RECV: begin
        if (!sts.fits)           op = OP_RECV_SMALL;
        else if (sts.note_any)   op = OP_RECV_DELIVER;
        else if (!sts.wait_full) op = OP_RECV_PEND;
        else                     op = OP_RECV_FULL;
      end
      REQ_CANCEL: op = sts.match_any ? OP_CANCEL_HIT : OP_CANCEL_MISS;
      default: op = OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.op      = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        cmd.op    = op;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r == S_EXEC);

endmodule

// ===== rtl/notify_request_rendezvous_queue.sv =====
// Top level: notification / read-request rendezvous queue.
// A request is captured, then executed; its result is registered and strobed on out_valid.
// A new request is taken only in the idle state; busy is high in the execute cycle.
// Capture and execute are split by the registered notification RAM read and tag-match register.
// Reserved request type is taken but produces no result. The receiver cannot stall results.
// Reset (rst_n low, synchronous) empties both queues; RAM and tag contents are left as they are.
module notify_request_rendezvous_queue #(
  parameter int NOTE_DEPTH = nrrq_pkg::NOTE_DEPTH_DEF,
  parameter int WAIT_DEPTH = nrrq_pkg::WAIT_DEPTH_DEF,
  parameter int DATA_WIDTH = nrrq_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request side
  input  logic                          start,
  output logic                          busy,
  input  logic [nrrq_pkg::REQ_W-1:0]    in_req_type,
  input  logic [nrrq_pkg::DATA_P_W-1:0] in_notify_data,
  input  logic [nrrq_pkg::TAG_W-1:0]    in_request_tag,
  input  logic                          in_buffer_fits,
  // result side, one-cycle strobe
  output logic                          out_valid,
  output logic [nrrq_pkg::STATUS_W-1:0] out_status_code,
  output logic [nrrq_pkg::TAG_W-1:0]    out_completed_tag,
  output logic [nrrq_pkg::DATA_P_W-1:0] out_delivered_data
);
  import nrrq_pkg::*;

  cmd_t cmd;  // controller -> datapath: capture / execute strobes and operation
  sts_t sts;  // datapath -> controller: captured request and queue flags

  nrrq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath holds the notification RAM (registered read at the head pointer)
  // and the waiting-tag queue, which compacts on delivery or cancel
  nrrq_dp #(
    .NOTE_DEPTH (NOTE_DEPTH),
    .WAIT_DEPTH (WAIT_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_req_type),
    .in_notify_data     (in_notify_data),
    .in_request_tag     (in_request_tag),
    .in_buffer_fits     (in_buffer_fits),
    .out_valid          (out_valid),
    .out_status_code    (out_status_code),
    .out_completed_tag  (out_completed_tag),
    .out_delivered_data (out_delivered_data)
  );

endmodule
